### hdl/ole_pkg.sv
package ole_pkg;

  localparam int VAL_W = 32;
  localparam int LEN_W = 5;
  localparam int POS_W = 8;

  // operation codes carried in the input word
  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DEL_KEY = 3'd2,
    OP_DEL_POS = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_RANGE     = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  // what every cell does with its value this cycle
  typedef enum logic [2:0] {
    CA_HOLD,
    CA_APPEND,
    CA_INSERT,
    CA_DEL_KEY,
    CA_DEL_POS,
    CA_ROTATE
  } cell_act_t;

  typedef struct packed {
    cell_act_t action;
    logic      clear_seen;
    logic      step_seen;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIX,
    S_RESULT,
    S_READ
  } state_t;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [VAL_W-1:0] key;
    logic signed [VAL_W-1:0] new_value;
    logic [POS_W-1:0]        position;
  } in_word_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [VAL_W-1:0] element;
    logic                    last;
    logic [LEN_W-1:0]        length;
  } out_word_t;

endpackage

### hdl/ole_cell.sv
module ole_cell #(
  parameter int CAPACITY = 16,
  parameter int IDX = 0,
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ole_pkg::cell_ctl_t             ctl,
  input  logic [CW-1:0]                  count,
  input  logic [ole_pkg::POS_W-1:0]      position,
  input  logic signed [ole_pkg::VAL_W-1:0] key,
  input  logic signed [ole_pkg::VAL_W-1:0] new_value,
  input  logic signed [ole_pkg::VAL_W-1:0] left_value,
  input  logic signed [ole_pkg::VAL_W-1:0] right_value,
  input  logic signed [ole_pkg::VAL_W-1:0] wrap_value,
  input  logic                           seen_in,
  output logic signed [ole_pkg::VAL_W-1:0] value,
  output logic                           seen_out
);

  localparam int PW = ((CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W) + 1;

  logic seen;
  logic occupied;
  logic match;
  logic at_count;
  logic at_tail;
  logic at_or_after_pos;

  // local decode of where this cell sits relative to the list
  assign occupied        = CW'(IDX) < count;
  assign match           = occupied && (value == key);
  assign at_count        = CW'(IDX) == count;
  assign at_tail         = CW'(IDX + 1) == count;
  assign at_or_after_pos = PW'(IDX + 1) >= PW'(position);
  assign seen_out        = seen | match;

  // "an earlier cell matched" flag, moves one cell per step
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_seen) begin
      seen <= 1'b0;
    end else if (ctl.step_seen) begin
      seen <= seen_in;
    end
  end

  // value register: load, shift toward either neighbor, or rotate
  always_ff @(posedge clk) begin
    case (ctl.action)
      ole_pkg::CA_APPEND: begin
        if (at_count) value <= new_value;
      end
      ole_pkg::CA_INSERT: begin
        if (seen) value <= left_value;
        else if (match) value <= new_value;
      end
      ole_pkg::CA_DEL_KEY: begin
        if (seen || match) value <= right_value;
      end
      ole_pkg::CA_DEL_POS: begin
        if (at_or_after_pos) value <= right_value;
      end
      ole_pkg::CA_ROTATE: begin
        if (at_tail) value <= wrap_value;
        else value <= right_value;
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

### hdl/ordered_list_engine.sv
// Sequence: append, delete by position and refused ops go through the execute state, then
// load their output word from the result state; insert-before and delete-by-key pass the scan
// and fix states in between, the match flag moving one cell per cycle down the chain. A readout
// goes from execute to the read state, which gives one word per cycle while the output is free
// (the list rotates through cell 0). Throughput: one operation at a time, a new input word taken
// only after the last word of the one before. Reset: synchronous, clears count and control only.
module ordered_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ole_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output ole_pkg::out_word_t  out_word
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY);
  localparam int PW = ((CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W) + 1;

  ole_pkg::state_t    state, state_next;
  ole_pkg::cell_ctl_t ctl;
  ole_pkg::status_t   res_status, res_status_next;
  ole_pkg::out_word_t load_word;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd, rd_next;
  logic [SW-1:0] scnt, scnt_next;
  logic          found;
  logic          load_out;
  logic          out_free;
  logic          full;
  logic          rd_last;

  logic [2:0]                     op_r;
  logic signed [ole_pkg::VAL_W-1:0] key_r;
  logic signed [ole_pkg::VAL_W-1:0] new_r;
  logic [ole_pkg::POS_W-1:0]      pos_r;

  logic signed [ole_pkg::VAL_W-1:0] vals [CAPACITY];
  logic [CAPACITY:0]              seen_chain;

  assign in_ready = (state == ole_pkg::S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign full     = (count == CW'(CAPACITY));
  assign rd_last  = (CW'(rd + 1'b1) == count);

  // row of cells, element 1 in cell 0
  assign seen_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ole_pkg::VAL_W-1:0] left_v;
    logic signed [ole_pkg::VAL_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = new_r;
    end else begin : g_mid_l
      assign left_v = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = vals[i];
    end else begin : g_mid_r
      assign right_v = vals[i+1];
    end

    ole_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i),
      .CW       (CW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .count       (count),
      .position    (pos_r),
      .key         (key_r),
      .new_value   (new_r),
      .left_value  (left_v),
      .right_value (right_v),
      .wrap_value  (vals[0]),
      .seen_in     (seen_chain[i]),
      .value       (vals[i]),
      .seen_out    (seen_chain[i+1])
    );
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_word.op;
      key_r <= in_word.key;
      new_r <= in_word.new_value;
      pos_r <= in_word.position;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ole_pkg::S_IDLE;
      count      <= '0;
      rd         <= '0;
      scnt       <= '0;
      res_status <= ole_pkg::ST_OK;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rd         <= rd_next;
      scnt       <= scnt_next;
      res_status <= res_status_next;
    end
  end

  // match flag leaving the last cell: final once the scan has covered the whole row
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_seen) begin
      found <= 1'b0;
    end else if (ctl.step_seen) begin
      found <= seen_chain[CAPACITY];
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_next         = rd;
    scnt_next       = scnt;
    res_status_next = res_status;
    ctl.action      = ole_pkg::CA_HOLD;
    ctl.clear_seen  = 1'b0;
    ctl.step_seen   = 1'b0;
    load_out        = 1'b0;
    load_word       = '0;

    case (state)
      ole_pkg::S_IDLE: begin
        if (in_valid) state_next = ole_pkg::S_EXEC;
      end

      ole_pkg::S_EXEC: begin
        state_next = ole_pkg::S_RESULT;
        case (op_r)
          ole_pkg::OP_APPEND: begin
            if (full) begin
              res_status_next = ole_pkg::ST_FULL;
            end else begin
              ctl.action      = ole_pkg::CA_APPEND;
              count_next      = count + 1'b1;
              res_status_next = ole_pkg::ST_OK;
            end
          end
          ole_pkg::OP_INSERT: begin
            if (full) begin
              res_status_next = ole_pkg::ST_FULL;
            end else begin
              ctl.clear_seen = 1'b1;
              scnt_next      = '0;
              state_next     = ole_pkg::S_SCAN;
            end
          end
          ole_pkg::OP_DEL_KEY: begin
            ctl.clear_seen = 1'b1;
            scnt_next      = '0;
            state_next     = ole_pkg::S_SCAN;
          end
          ole_pkg::OP_DEL_POS: begin
            if (count == '0) begin
              res_status_next = ole_pkg::ST_EMPTY;
            end else if (pos_r == '0) begin
              res_status_next = ole_pkg::ST_BAD_POS;
            end else if (PW'(pos_r) > PW'(count)) begin
              res_status_next = ole_pkg::ST_RANGE;
            end else begin
              ctl.action      = ole_pkg::CA_DEL_POS;
              count_next      = count - 1'b1;
              res_status_next = ole_pkg::ST_OK;
            end
          end
          ole_pkg::OP_READ: begin
            if (count == '0) begin
              res_status_next = ole_pkg::ST_EMPTY;
            end else begin
              rd_next    = '0;
              state_next = ole_pkg::S_READ;
            end
          end
          default: begin
            res_status_next = ole_pkg::ST_OK;
          end
        endcase
      end

      // one cell of match flag propagation per cycle
      ole_pkg::S_SCAN: begin
        ctl.step_seen = 1'b1;
        scnt_next     = scnt + 1'b1;
        if (scnt == SW'(CAPACITY - 1)) state_next = ole_pkg::S_FIX;
      end

      ole_pkg::S_FIX: begin
        state_next = ole_pkg::S_RESULT;
        if (!found) begin
          res_status_next = ole_pkg::ST_NOT_FOUND;
        end else if (op_r == ole_pkg::OP_INSERT) begin
          ctl.action      = ole_pkg::CA_INSERT;
          count_next      = count + 1'b1;
          res_status_next = ole_pkg::ST_OK;
        end else begin
          ctl.action      = ole_pkg::CA_DEL_KEY;
          count_next      = count - 1'b1;
          res_status_next = ole_pkg::ST_OK;
        end
      end

      ole_pkg::S_RESULT: begin
        if (out_free) begin
          load_out         = 1'b1;
          load_word.status = res_status;
          load_word.last   = 1'b1;
          load_word.length = ole_pkg::LEN_W'(count);
          state_next       = ole_pkg::S_IDLE;
        end
      end

      // readout: emit cell 0, rotate the list left by one
      ole_pkg::S_READ: begin
        if (out_free) begin
          load_out          = 1'b1;
          load_word.status  = ole_pkg::ST_OK;
          load_word.element = vals[0];
          load_word.last    = rd_last;
          load_word.length  = ole_pkg::LEN_W'(count);
          ctl.action        = ole_pkg::CA_ROTATE;
          rd_next           = rd + 1'b1;
          if (rd_last) state_next = ole_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ole_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_word <= load_word;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == CW'($past(count) + 1'b1)) || (count == CW'($past(count) - 1'b1)))
    else $error("element count moved by more than one");

  a_not_last_is_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.last) |-> (out_word.status == ole_pkg::ST_OK))
    else $error("non-final word with error status");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while operation pending");

endmodule
